[src/stt_pkg.sv]
package stt_pkg;

    // Fixed field widths of the result channel
    localparam int OFFSET_BITS = 16;
    localparam int LENGTH_BITS = 16;
    localparam int VALUE_BITS  = 64;

    // Result queue between the lexer and the output port
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_IDX_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    // Token kinds
    typedef enum logic [2:0] {
        KIND_END     = 3'd0,
        KIND_KEYWORD = 3'd1,
        KIND_IDENT   = 3'd2,
        KIND_NUMBER  = 3'd3,
        KIND_STRING  = 3'd4,
        KIND_SYMBOL  = 3'd5,
        KIND_INVALID = 3'd6
    } kind_t;

    // Symbol codes
    localparam logic [2:0] SYM_NONE   = 3'd0;
    localparam logic [2:0] SYM_LPAREN = 3'd0;
    localparam logic [2:0] SYM_RPAREN = 3'd1;
    localparam logic [2:0] SYM_LBRACE = 3'd2;
    localparam logic [2:0] SYM_RBRACE = 3'd3;
    localparam logic [2:0] SYM_COMMA  = 3'd4;
    localparam logic [2:0] SYM_SEMI   = 3'd5;
    localparam logic [2:0] SYM_QUOTE  = 3'd6;

    // Character codes
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_LPAREN    = 8'h28;
    localparam logic [7:0] CH_RPAREN    = 8'h29;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_SEMI      = 8'h3B;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;

    localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

    // One result token
    typedef struct packed {
        kind_t                  kind;
        logic [2:0]             symbol;
        logic [OFFSET_BITS-1:0] start;
        logic [LENGTH_BITS-1:0] length;
        logic [VALUE_BITS-1:0]  value;
        logic                   overflow;
        logic                   last;
    } token_t;

    // Tokens produced by one accepted byte, in order
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } token_push_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
    endfunction

endpackage

[src/stt_lexer.sv]
module stt_lexer #(
    parameter int POSITION_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [7:0]           text_byte,
    output stt_pkg::token_push_t push
);
    import stt_pkg::*;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_NUMBER = 3'd1,
        MODE_WORD   = 3'd2,
        MODE_STRING = 3'd3,
        MODE_ESCAPE = 3'd4
    } mode_t;

    localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

    mode_t                   mode_reg, mode_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LENGTH_BITS-1:0]  len_reg, len_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic                    sat_reg, sat_next;
    logic [1:0]              kw_reg, kw_next;

    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] start_dec;
    logic [LENGTH_BITS-1:0]   len_grow;
    logic [7:0]               digit;
    logic [VALUE_BITS+3:0]    acc_times_ten;
    logic                     acc_wraps;

    // Outcome of lexing the byte as the start of something new
    logic                     fr_emit;
    logic                     fr_end;
    token_t                   fr_tok;
    mode_t                    fr_mode;
    logic [POSITION_BITS-1:0] fr_start;
    logic [LENGTH_BITS-1:0]   fr_len;
    logic [VALUE_BITS-1:0]    fr_acc;
    logic                     fr_sat;
    logic [1:0]               fr_kw;

    logic                     use_fresh;
    logic                     closed_valid;
    token_t                   closed_tok;
    logic                     ended;
    token_push_t              push_comb;

    assign pos_inc   = pos_reg + POS_ONE;
    assign start_dec = start_reg - POS_ONE;
    assign len_grow  = (len_reg == LENGTH_MAX) ? len_reg : len_reg + 1'b1;
    assign digit     = text_byte - CH_ZERO;

    // acc * 10 + digit, with four guard bits to spot overflow
    assign acc_times_ten = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) +
                           (VALUE_BITS + 4)'(digit);
    assign acc_wraps     = sat_reg || (acc_times_ten[VALUE_BITS+3:VALUE_BITS] != 4'd0);

    // Fresh lex of the current byte
    always_comb begin
        fr_emit         = 1'b0;
        fr_end          = 1'b0;
        fr_tok          = '0;
        fr_tok.kind     = KIND_INVALID;
        fr_tok.symbol   = SYM_NONE;
        fr_tok.start    = OFFSET_BITS'(pos_reg);
        fr_tok.length   = LENGTH_BITS'(1);
        fr_mode         = MODE_IDLE;
        fr_start        = start_reg;
        fr_len          = len_reg;
        fr_acc          = acc_reg;
        fr_sat          = sat_reg;
        fr_kw           = 2'd0;
        if (text_byte == CH_NUL) begin
            fr_emit       = 1'b1;
            fr_end        = 1'b1;
            fr_tok.kind   = KIND_END;
            fr_tok.length = '0;
        end else if (is_space(text_byte)) begin
            fr_emit = 1'b0;
        end else if (is_digit(text_byte)) begin
            fr_mode  = MODE_NUMBER;
            fr_start = pos_reg;
            fr_len   = LENGTH_BITS'(1);
            fr_acc   = VALUE_BITS'(digit);
            fr_sat   = 1'b0;
        end else if (is_letter(text_byte)) begin
            fr_mode  = MODE_WORD;
            fr_start = pos_reg;
            fr_len   = LENGTH_BITS'(1);
            fr_kw    = (text_byte == CH_LOWER_F) ? 2'd1 : 2'd0;
        end else if (text_byte == CH_DQUOTE) begin
            fr_mode  = MODE_STRING;
            fr_start = pos_inc;
            fr_len   = '0;
        end else begin
            fr_emit     = 1'b1;
            fr_tok.kind = KIND_SYMBOL;
            case (text_byte)
                CH_LPAREN: fr_tok.symbol = SYM_LPAREN;
                CH_RPAREN: fr_tok.symbol = SYM_RPAREN;
                CH_LBRACE: fr_tok.symbol = SYM_LBRACE;
                CH_RBRACE: fr_tok.symbol = SYM_RBRACE;
                CH_COMMA:  fr_tok.symbol = SYM_COMMA;
                CH_SEMI:   fr_tok.symbol = SYM_SEMI;
                default: begin
                    fr_tok.kind   = KIND_INVALID;
                    fr_tok.symbol = SYM_NONE;
                end
            endcase
        end
    end

    // Continue or close the pending token
    always_comb begin
        mode_next             = mode_reg;
        start_next            = start_reg;
        len_next              = len_reg;
        acc_next              = acc_reg;
        sat_next              = sat_reg;
        kw_next               = kw_reg;
        use_fresh             = 1'b0;
        closed_valid          = 1'b0;
        closed_tok            = '0;
        closed_tok.kind       = KIND_NUMBER;
        closed_tok.symbol     = SYM_NONE;
        closed_tok.start      = OFFSET_BITS'(start_reg);
        closed_tok.length     = len_reg;
        case (mode_reg)
            MODE_NUMBER: begin
                if (is_digit(text_byte)) begin
                    len_next = len_grow;
                    sat_next = acc_wraps;
                    acc_next = acc_wraps ? '1 : acc_times_ten[VALUE_BITS-1:0];
                end else begin
                    closed_valid        = 1'b1;
                    closed_tok.kind     = KIND_NUMBER;
                    closed_tok.value    = acc_reg;
                    closed_tok.overflow = sat_reg;
                    use_fresh           = 1'b1;
                end
            end
            MODE_WORD: begin
                if (is_letter(text_byte) || is_digit(text_byte)) begin
                    len_next = len_grow;
                    kw_next  = (kw_reg == 2'd1 && text_byte == CH_LOWER_N) ? 2'd2 : 2'd0;
                end else begin
                    closed_valid    = 1'b1;
                    closed_tok.kind = (kw_reg == 2'd2) ? KIND_KEYWORD : KIND_IDENT;
                    use_fresh       = 1'b1;
                end
            end
            MODE_STRING, MODE_ESCAPE: begin
                if (text_byte == CH_NUL) begin
                    // unterminated string: invalid from the quote, then end
                    closed_valid      = 1'b1;
                    closed_tok.kind   = KIND_INVALID;
                    closed_tok.symbol = SYM_QUOTE;
                    closed_tok.start  = OFFSET_BITS'(start_dec);
                    closed_tok.length = len_grow;
                    use_fresh         = 1'b1;
                end else if (mode_reg == MODE_ESCAPE) begin
                    len_next  = len_grow;
                    mode_next = MODE_STRING;
                end else if (text_byte == CH_DQUOTE) begin
                    closed_valid    = 1'b1;
                    closed_tok.kind = KIND_STRING;
                    mode_next       = MODE_IDLE;
                end else begin
                    len_next = len_grow;
                    if (text_byte == CH_BACKSLASH) begin
                        mode_next = MODE_ESCAPE;
                    end
                end
            end
            default: begin
                use_fresh = 1'b1;
            end
        endcase

        if (use_fresh) begin
            mode_next  = fr_mode;
            start_next = fr_start;
            len_next   = fr_len;
            acc_next   = fr_acc;
            sat_next   = fr_sat;
            kw_next    = fr_kw;
        end

        ended    = use_fresh && fr_end;
        pos_next = pos_inc;
        if (ended) begin
            mode_next  = MODE_IDLE;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
            acc_next   = '0;
            sat_next   = 1'b0;
            kw_next    = 2'd0;
        end
    end

    // Pack the tokens in order and mark the last one
    always_comb begin
        push_comb = '0;
        if (closed_valid) begin
            push_comb.first  = closed_tok;
            push_comb.second = fr_tok;
            push_comb.count  = (use_fresh && fr_emit) ? 2'd2 : 2'd1;
        end else begin
            push_comb.first  = fr_tok;
            push_comb.second = fr_tok;
            push_comb.count  = (use_fresh && fr_emit) ? 2'd1 : 2'd0;
        end
        if (push_comb.count == 2'd2) begin
            push_comb.second.last = 1'b1;
        end else begin
            push_comb.first.last = 1'b1;
        end
        if (!accept) begin
            push_comb.count = 2'd0;
        end
    end

    assign push = push_comb;

    // Scanner state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            acc_reg   <= '0;
            sat_reg   <= 1'b0;
            kw_reg    <= 2'd0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            acc_reg   <= acc_next;
            sat_reg   <= sat_next;
            kw_reg    <= kw_next;
        end
    end

`ifndef SYNTHESIS
    // Only a closed number, word or unterminated string can precede a second token
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.count == 2'd2 |-> (push.first.kind == KIND_NUMBER ||
                                push.first.kind == KIND_IDENT ||
                                push.first.kind == KIND_KEYWORD ||
                                push.first.kind == KIND_INVALID))
        else $error("stt_lexer: unexpected first token of a pair");

    // An end token restarts the text at offset zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        ((push.count == 2'd1 && push.first.kind == KIND_END) ||
         (push.count == 2'd2 && push.second.kind == KIND_END))
        |=> (pos_reg == '0 && mode_reg == MODE_IDLE))
        else $error("stt_lexer: state not cleared after end token");

    // Overflow flag only on number tokens
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push.count != 2'd0 && push.first.kind != KIND_NUMBER) |-> !push.first.overflow)
        else $error("stt_lexer: overflow on a non-number token");
`endif

endmodule

[src/stt_token_queue.sv]
module stt_token_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  stt_pkg::token_push_t push,
    input  logic                 pop,
    output stt_pkg::token_t      head,
    output logic                 head_valid,
    output logic                 room_for_two
);
    import stt_pkg::*;

    token_t                    q_reg [QUEUE_DEPTH];
    logic [QUEUE_IDX_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_IDX_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] cnt_reg;
    logic [QUEUE_IDX_BITS-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    // Token storage
    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            q_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            q_reg[wr_ptr_plus1] <= push.second;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QUEUE_IDX_BITS'(push.count);
            rd_ptr_reg <= rd_ptr_reg + QUEUE_IDX_BITS'(pop);
            cnt_reg    <= cnt_reg + QUEUE_CNT_BITS'(push.count) - QUEUE_CNT_BITS'(pop);
        end
    end

    assign head         = q_reg[rd_ptr_reg];
    assign head_valid   = (cnt_reg != '0);
    assign room_for_two = (cnt_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH - 2));

`ifndef SYNTHESIS
    // Fill count stays within the queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("stt_token_queue: fill count out of range");

    // No read from an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> cnt_reg != '0)
        else $error("stt_token_queue: pop while empty");

    // Writes only land when two slots are free
    assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> room_for_two)
        else $error("stt_token_queue: push without room");
`endif

endmodule

[src/source_text_tokenizer_unit.sv]
// Channel | Direction | Ports                                   | Transaction
// s_      | in        | s_valid, s_ready, s_text_byte           | one source byte
// m_      | out       | m_valid, m_ready, m_token_kind ...      | one token
//
// One byte is taken per cycle while s_ready is high; its tokens (none, one or two) are
// written into a four-entry token queue in the same edge and shown in order from the queue head.
// The queue drains one token per cycle while m_ready is high, so s_ready drops only while
// fewer than two entries are free. Reset (aresetn low, synchronous) empties the queue and
// restarts the text at offset 0. A stalled m_ side holds the head token unchanged.
module source_text_tokenizer_unit #(
    parameter int POSITION_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_text_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_token_kind,
    output logic [2:0]  m_symbol_code,
    output logic [15:0] m_start_offset,
    output logic [15:0] m_token_length,
    output logic [63:0] m_number_value,
    output logic        m_number_overflow,
    output logic        m_last_of_run
);
    import stt_pkg::*;

    logic        in_accept;
    logic        out_accept;
    token_push_t push;
    token_t      head;

    assign in_accept  = s_valid && s_ready;
    assign out_accept = m_valid && m_ready;

    // Scanner
    stt_lexer #(
        .POSITION_BITS(POSITION_BITS)
    ) u_lexer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (in_accept),
        .text_byte (s_text_byte),
        .push      (push)
    );

    // Token queue feeding the result channel
    stt_token_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .pop          (out_accept),
        .head         (head),
        .head_valid   (m_valid),
        .room_for_two (s_ready)
    );

    assign m_token_kind      = head.kind;
    assign m_symbol_code     = head.symbol;
    assign m_start_offset    = head.start;
    assign m_token_length    = head.length;
    assign m_number_value    = head.value;
    assign m_number_overflow = head.overflow;
    assign m_last_of_run     = head.last;

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int IDLE_LIMIT    = 2000;  // cycles with no transaction on either side
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_BYTES  = 1200;  // bytes in the random part

    // Lexer modes of the predictor
    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_NUMBER,
        SCAN_WORD,
        SCAN_STRING,
        SCAN_ESCAPE
    } scan_t;

    // One source byte waiting to be sent
    typedef struct {
        logic [7:0] ch;
        bit         drain;  // hold off until every expected token has come
        bit         rush;   // send without a gap
    } text_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_text_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_token_kind;
    logic [2:0]  m_symbol_code;
    logic [15:0] m_start_offset;
    logic [15:0] m_token_length;
    logic [63:0] m_number_value;
    logic        m_number_overflow;
    logic        m_last_of_run;

    text_item_t  pending_bytes[$];
    token_t      expected_tokens[$];
    token_t      step_tokens[$];

    // Predictor state
    scan_t       scan_state = SCAN_IDLE;
    logic [15:0] text_pos = '0;
    logic [15:0] tok_start = '0;
    logic [15:0] tok_len = '0;
    logic [63:0] num_acc = '0;
    logic        num_sat = 1'b0;
    logic [1:0]  fn_match = '0;

    int          bytes_left = 0;
    int          payload_bytes = 0;
    int          send_gap = 0;
    int          ready_gap = 0;
    int          idle_cycles = 0;
    int unsigned cycle_count = 0;
    int          failures = 0;
    int          tokens_checked = 0;
    int          saturated_seen = 0;
    int          drains_done = 0;
    int          kind_seen[8];
    bit          timed_out = 1'b0;

    always #4 aclk = ~aclk;

    source_text_tokenizer_unit DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_text_byte       (s_text_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_token_kind      (m_token_kind),
        .m_symbol_code     (m_symbol_code),
        .m_start_offset    (m_start_offset),
        .m_token_length    (m_token_length),
        .m_number_value    (m_number_value),
        .m_number_overflow (m_number_overflow),
        .m_last_of_run     (m_last_of_run)
    );

    // ---------------------------------------------------------------- byte classes

    function automatic bit is_blank(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_decimal(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
    endfunction

    // Symbol code of a punctuation byte; found is 0 for anything else
    function automatic logic [2:0] symbol_for(logic [7:0] c, output bit found);
        found = 1'b1;
        case (c)
            CH_LPAREN: return SYM_LPAREN;
            CH_RPAREN: return SYM_RPAREN;
            CH_LBRACE: return SYM_LBRACE;
            CH_RBRACE: return SYM_RBRACE;
            CH_COMMA:  return SYM_COMMA;
            CH_SEMI:   return SYM_SEMI;
            default: begin
                found = 1'b0;
                return SYM_NONE;
            end
        endcase
    endfunction

    // ---------------------------------------------------------------- token predictor

    function automatic void add_token(kind_t kind, logic [2:0] sym, logic [15:0] start,
                                      logic [15:0] len, logic [63:0] value, logic ovf);
        token_t t;
        t.kind     = kind;
        t.symbol   = sym;
        t.start    = start;
        t.length   = len;
        t.value    = value;
        t.overflow = ovf;
        t.last     = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void clear_lexer();
        scan_state = SCAN_IDLE;
        text_pos   = '0;
        tok_start  = '0;
        tok_len    = '0;
        num_acc    = '0;
        num_sat    = 1'b0;
        fn_match   = '0;
    endfunction

    function automatic void bump_len();
        if (tok_len != LENGTH_MAX)
            tok_len = tok_len + 16'd1;
    endfunction

    // Byte that opens something new; returns 1 when it ends the text
    function automatic bit start_fresh(logic [7:0] c);
        logic [2:0] sym;
        bit         found;
        if (c == CH_NUL) begin
            add_token(KIND_END, SYM_NONE, text_pos, '0, '0, 1'b0);
            return 1'b1;
        end
        if (is_blank(c))
            return 1'b0;
        if (is_decimal(c)) begin
            scan_state = SCAN_NUMBER;
            tok_start  = text_pos;
            tok_len    = 16'd1;
            num_acc    = 64'(c - CH_ZERO);
            num_sat    = 1'b0;
        end else if (is_alpha(c)) begin
            scan_state = SCAN_WORD;
            tok_start  = text_pos;
            tok_len    = 16'd1;
            fn_match   = (c == CH_LOWER_F) ? 2'd1 : 2'd0;
        end else if (c == CH_DQUOTE) begin
            scan_state = SCAN_STRING;
            tok_start  = text_pos + 16'd1;
            tok_len    = '0;
        end else begin
            sym = symbol_for(c, found);
            if (found)
                add_token(KIND_SYMBOL, sym, text_pos, 16'd1, '0, 1'b0);
            else
                add_token(KIND_INVALID, SYM_NONE, text_pos, 16'd1, '0, 1'b0);
        end
        return 1'b0;
    endfunction

    // Works out the tokens of one accepted byte and queues them
    function automatic void predict_tokens(logic [7:0] c);
        logic [67:0] grown;
        bit          ended;
        ended = 1'b0;
        step_tokens.delete();
        case (scan_state)
            SCAN_NUMBER: begin
                if (is_decimal(c)) begin
                    bump_len();
                    grown = 68'(num_acc) * 68'd10 + 68'(c - CH_ZERO);
                    if (num_sat || grown[67:64] != 4'd0) begin
                        num_sat = 1'b1;
                        num_acc = '1;
                    end else begin
                        num_acc = grown[63:0];
                    end
                end else begin
                    add_token(KIND_NUMBER, SYM_NONE, tok_start, tok_len, num_acc, num_sat);
                    scan_state = SCAN_IDLE;
                    ended = start_fresh(c);
                end
            end
            SCAN_WORD: begin
                if (is_alpha(c) || is_decimal(c)) begin
                    bump_len();
                    fn_match = (fn_match == 2'd1 && c == CH_LOWER_N) ? 2'd2 : 2'd0;
                end else begin
                    add_token((fn_match == 2'd2) ? KIND_KEYWORD : KIND_IDENT, SYM_NONE,
                              tok_start, tok_len, '0, 1'b0);
                    scan_state = SCAN_IDLE;
                    fn_match   = '0;
                    ended = start_fresh(c);
                end
            end
            SCAN_STRING, SCAN_ESCAPE: begin
                if (c == CH_NUL) begin
                    // unterminated: report from the opening quote, then close the text
                    add_token(KIND_INVALID, SYM_QUOTE, tok_start - 16'd1,
                              (tok_len == LENGTH_MAX) ? LENGTH_MAX : tok_len + 16'd1,
                              '0, 1'b0);
                    add_token(KIND_END, SYM_NONE, text_pos, '0, '0, 1'b0);
                    ended = 1'b1;
                end else if (scan_state == SCAN_ESCAPE) begin
                    bump_len();
                    scan_state = SCAN_STRING;
                end else if (c == CH_DQUOTE) begin
                    add_token(KIND_STRING, SYM_NONE, tok_start, tok_len, '0, 1'b0);
                    scan_state = SCAN_IDLE;
                end else begin
                    bump_len();
                    if (c == CH_BACKSLASH)
                        scan_state = SCAN_ESCAPE;
                end
            end
            default: begin
                ended = start_fresh(c);
            end
        endcase

        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.push_back(step_tokens[i]);

        if (ended)
            clear_lexer();
        else
            text_pos = text_pos + 16'd1;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic void add_byte(logic [7:0] c, bit drain = 1'b0, bit rush = 1'b0);
        text_item_t t;
        t.ch    = c;
        t.drain = drain;
        t.rush  = rush;
        pending_bytes.push_back(t);
        payload_bytes++;
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endfunction

    function automatic logic [7:0] rand_alpha();
        int unsigned r = $urandom_range(0, 51);
        return (r < 26) ? 8'(CH_LOWER_A + r) : 8'(CH_UPPER_A + r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(0, 9));
    endfunction

    // Byte outside every class the lexer knows
    function automatic logic [7:0] rand_stray();
        logic [7:0] c;
        bit         found;
        do begin
            c = 8'($urandom_range(1, 255));
            void'(symbol_for(c, found));
        end while (found || is_blank(c) || is_decimal(c) || is_alpha(c) || c == CH_DQUOTE);
        return c;
    endfunction

    // String body of n characters, some of them escapes; no quote or NUL unescaped
    function automatic void add_string_body(int n);
        logic [7:0] c;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 15) begin
                add_byte(CH_BACKSLASH);
                add_byte(8'($urandom_range(1, 255)));
            end else begin
                do c = 8'($urandom_range(1, 255));
                while (c == CH_DQUOTE || c == CH_BACKSLASH);
                add_byte(c);
            end
        end
    endfunction

    function automatic void add_random_token();
        int unsigned n;
        logic [7:0]  prev;
        logic [7:0]  c;
        case ($urandom_range(0, 9))
            0: add_text("fn");
            1, 2: begin
                // word, often close to the keyword
                prev = ($urandom_range(0, 2) == 0) ? CH_LOWER_F : rand_alpha();
                add_byte(prev);
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) begin
                    if (prev == CH_LOWER_F && $urandom_range(0, 1) == 0)
                        c = CH_LOWER_N;
                    else
                        c = ($urandom_range(0, 9) < 7) ? rand_alpha() : rand_digit();
                    add_byte(c);
                    prev = c;
                end
            end
            3, 4: begin
                case ($urandom_range(0, 9))
                    0: add_text("18446744073709551615");
                    1: add_text("18446744073709551616");
                    2: n = $urandom_range(21, 26);
                    3: n = $urandom_range(7, 20);
                    default: n = $urandom_range(1, 6);
                endcase
                if (n > 0)
                    for (int i = 0; i < n; i++)
                        add_byte(rand_digit());
            end
            5: begin
                add_byte(CH_DQUOTE);
                add_string_body($urandom_range(0, 8));
                add_byte(CH_DQUOTE);
            end
            6, 7: begin
                case ($urandom_range(0, 5))
                    0: add_byte(CH_LPAREN);
                    1: add_byte(CH_RPAREN);
                    2: add_byte(CH_LBRACE);
                    3: add_byte(CH_RBRACE);
                    4: add_byte(CH_COMMA);
                    default: add_byte(CH_SEMI);
                endcase
            end
            default: add_byte(rand_stray());
        endcase
    endfunction

    // Mostly short gaps, a few long ones, and stretches with none at all
    function automatic int draw_gap();
        int unsigned r;
        if (cycle_count[10:9] == 2'b00)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            failures++;
        end
    endfunction

    // ---------------------------------------------------------------- byte driver

    always @(posedge aclk) begin : byte_driver
        text_item_t item;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_tokens(s_text_byte);
                bytes_left--;
            end
            if (s_valid && !s_ready) begin
                // transaction still pending: hold byte and valid
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_bytes.size() == 0 ||
                         (pending_bytes[0].drain && expected_tokens.size() != 0)) begin
                s_valid <= 1'b0;
            end else begin
                item = pending_bytes.pop_front();
                s_valid     <= 1'b1;
                s_text_byte <= item.ch;
                send_gap = item.rush ? 0 : draw_gap();
                if (item.drain)
                    drains_done++;
            end
        end
    end

    // ---------------------------------------------------------------- token monitor

    always @(posedge aclk) begin : token_monitor
        token_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_tokens.size() == 0) begin
                    $error("token with nothing expected: kind %0d, offset %0d",
                           m_token_kind, m_start_offset);
                    failures++;
                end else begin
                    want = expected_tokens.pop_front();
                    compare_field("token_kind", 64'(want.kind), 64'(m_token_kind));
                    compare_field("symbol_code", 64'(want.symbol), 64'(m_symbol_code));
                    compare_field("start_offset", 64'(want.start), 64'(m_start_offset));
                    compare_field("token_length", 64'(want.length), 64'(m_token_length));
                    compare_field("number_value", want.value, m_number_value);
                    compare_field("number_overflow", 64'(want.overflow),
                                  64'(m_number_overflow));
                    compare_field("last_of_run", 64'(want.last), 64'(m_last_of_run));
                    tokens_checked++;
                    kind_seen[int'(want.kind)]++;
                    if (want.overflow)
                        saturated_seen++;
                end
            end
            if (ready_gap > 0) begin
                ready_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                ready_gap = draw_gap();
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        foreach (kind_seen[i])
            kind_seen[i] = 0;

        // Directed: keyword, identifier, number, escaped string, symbols,
        // a stray high byte, end of text, then a string cut off after a backslash
        add_text("fn(x1,42,\"a\\\"b\"){;}");
        add_byte(8'hFF);
        add_byte(CH_NUL);
        add_text("\"q\\");
        add_byte(CH_NUL);

        // Random part: well-formed texts with random content, some noise
        payload_bytes = 0;
        for (int t = 0; payload_bytes < RANDOM_BYTES; t++) begin
            if ($urandom_range(0, 99) < 8) begin
                for (int i = $urandom_range(1, 6); i > 0; i--)
                    add_byte(8'($urandom_range(0, 255)));
            end else begin
                // a text built on the first pass always waits for the block to drain
                if (t == 0 || $urandom_range(0, 9) == 0)
                    add_byte(CH_SPACE, 1'b1);
                for (int k = $urandom_range(1, 10); k > 0; k--) begin
                    add_random_token();
                    if ($urandom_range(0, 1) == 0)
                        for (int i = $urandom_range(1, 2); i > 0; i--)
                            add_byte(8'($urandom_range(9, 14)) == 8'd14 ?
                                     CH_SPACE : 8'($urandom_range(9, 13)));
                end
                if ($urandom_range(0, 9) == 0) begin
                    add_byte(CH_DQUOTE);
                    add_string_body($urandom_range(0, 4));
                    if ($urandom_range(0, 1) == 0)
                        add_byte(CH_BACKSLASH);
                end
                add_byte(CH_NUL);
            end
        end
        bytes_left = pending_bytes.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        fork
            begin
                do @(posedge aclk);
                while (bytes_left != 0 || expected_tokens.size() != 0);
                repeat (SETTLE_CYCLES) @(posedge aclk);
            end
            begin
                do @(posedge aclk);
                while (idle_cycles < IDLE_LIMIT);
                timed_out = 1'b1;
            end
        join_any

        if (timed_out)
            $display("watchdog: no transaction for %0d cycles, %0d bytes unsent",
                     IDLE_LIMIT, bytes_left);
        else if (expected_tokens.size() != 0) begin
            $error("%0d expected tokens never arrived", expected_tokens.size());
            failures++;
        end

        $display("Covered %0d tokens: %0d keyword, %0d identifier, %0d number (%0d saturated)",
                 tokens_checked, kind_seen[KIND_KEYWORD], kind_seen[KIND_IDENT],
                 kind_seen[KIND_NUMBER], saturated_seen);
        $display("  %0d string, %0d symbol, %0d invalid, %0d end of text; %0d drain pauses",
                 kind_seen[KIND_STRING], kind_seen[KIND_SYMBOL], kind_seen[KIND_INVALID],
                 kind_seen[KIND_END], drains_done);

        if (!timed_out && failures == 0)
            $display("PASS source_text_tokenizer_unit");
        else
            $display("FAIL source_text_tokenizer_unit");
        $finish;
    end

endmodule
